>>> src/serial_tx_bulk_packetizer_defines.svh
// Assertion macros used by the serial transmit packetizer datapath.
`ifndef SERIAL_TX_BULK_PACKETIZER_DEFINES_SVH
`define SERIAL_TX_BULK_PACKETIZER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock, off during reset.
`define STB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on the rising clock, off during reset.
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define STB_ASSERT_NOW(lbl, ante, cons, msg)
`define STB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/stb_pkg.sv
// Package with the types, codes and constants of the serial transmit packetizer.
package stb_pkg;

    // Default sizes handed to the top level parameters.
    localparam int TX_DEPTH_DEF     = 256;
    localparam int PACKET_BYTES_DEF = 64;

    // Byte codes and reset values.
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [15:0] STATUS_RESET = 16'h00B0;

    // Request codes on the input channel.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_SENT = 1'b1;

    // Result kinds on the output channel.
    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_PKT = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR_LO,
        ST_HDR_HI,
        ST_DATA
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_push;
        logic accept_sent;
        logic load_hdr_lo;
        logic load_hdr_hi;
        logic load_data;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic chunk_zero;
        logic data_last;
    } t_dp_status;

endpackage

>>> src/stb_ifs.sv
// Handshake interfaces for the input, output and configuration channels.
interface stb_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] put_byte;

    modport source (output valid, output req_type, output put_byte, input ready);
    modport sink   (input valid, input req_type, input put_byte, output ready);
endinterface

interface stb_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic       accepted;
    logic [7:0] packet_byte;
    logic       last;

    modport source (output valid, output result_kind, output accepted,
                    output packet_byte, output last, input ready);
    modport sink   (input valid, input result_kind, input accepted,
                    input packet_byte, input last, output ready);
endinterface

interface stb_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/stb_ctrl.sv
// Controller state machine that sequences pushes and packet emission.
module stb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    input  stb_pkg::t_dp_status i_status,
    output logic               o_in_ready,
    output stb_pkg::t_ctrl_cmd o_cmd
);
    import stb_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                // A word is taken only when the output register can take its result.
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_req_type == REQ_PUSH) begin
                        o_cmd.accept_push = 1'b1;
                    end else begin
                        o_cmd.accept_sent = 1'b1;
                        n_state           = ST_HDR_LO;
                    end
                end
            end
            ST_HDR_LO: begin
                if (i_status.out_free) begin
                    o_cmd.load_hdr_lo = 1'b1;
                    n_state           = ST_HDR_HI;
                end
            end
            ST_HDR_HI: begin
                if (i_status.out_free) begin
                    o_cmd.load_hdr_hi = 1'b1;
                    n_state           = i_status.chunk_zero ? ST_IDLE : ST_DATA;
                end
            end
            ST_DATA: begin
                if (i_status.out_free) begin
                    o_cmd.load_data = 1'b1;
                    if (i_status.data_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/stb_dp.sv
// Datapath with the ring memory, pointers, counters and the output register.
`include "serial_tx_bulk_packetizer_defines.svh"
module stb_dp #(
    parameter int TX_DEPTH     = stb_pkg::TX_DEPTH_DEF,
    parameter int PACKET_BYTES = stb_pkg::PACKET_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_put_byte,
    input  stb_pkg::t_ctrl_cmd  i_cmd,
    output stb_pkg::t_dp_status o_status,
    stb_out_if.source           o_out,
    stb_cfg_if.sink             i_cfg
);
    import stb_pkg::*;

    localparam int PW = $clog2(TX_DEPTH);
    localparam int FW = $clog2(TX_DEPTH + 1);
    localparam int CW = $clog2(PACKET_BYTES - 1);
    localparam int MW = (FW > CW) ? FW : CW;
    localparam int SW = FW + 1;

    logic [7:0] r_ring [TX_DEPTH];

    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW-1:0] r_fetch_ptr, n_fetch_ptr;
    logic [FW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_inflight, n_inflight;
    logic [CW-1:0] r_remain, n_remain;
    logic [15:0]   r_status_word, n_status_word;
    logic [7:0]    r_rd_data;
    logic          r_out_valid, n_out_valid;
    logic          r_out_kind, n_out_kind;
    logic          r_out_acc, n_out_acc;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;

    logic          push_ok;
    logic          rd_en;
    logic          out_load;
    logic [MW-1:0] retire_m;
    logic [MW-1:0] chunk_m;
    logic [FW-1:0] fill_after;
    logic [SW-1:0] rd_sum;
    logic [PW-1:0] rd_wrapped;

    // Push check: the last free slot is kept for a newline.
    always_comb begin
        if (i_put_byte == NEWLINE_CODE) begin
            push_ok = r_fill < FW'(TX_DEPTH);
        end else begin
            push_ok = r_fill < FW'(TX_DEPTH - 1);
        end
    end

    // Retire the chunk in flight and size the next one.
    always_comb begin
        retire_m   = (MW'(r_inflight) > MW'(r_fill)) ? MW'(r_fill) : MW'(r_inflight);
        fill_after = r_fill - FW'(retire_m);
        chunk_m    = (MW'(fill_after) > MW'(PACKET_BYTES - 2)) ? MW'(PACKET_BYTES - 2)
                                                               : MW'(fill_after);
        rd_sum     = SW'(r_rd_ptr) + SW'(retire_m);
        rd_wrapped = (rd_sum >= SW'(TX_DEPTH)) ? PW'(rd_sum - SW'(TX_DEPTH)) : PW'(rd_sum);
    end

    assign out_load = i_cmd.accept_push | i_cmd.load_hdr_lo | i_cmd.load_hdr_hi
                    | i_cmd.load_data;
    assign rd_en    = i_cmd.load_hdr_hi | i_cmd.load_data;

    // Next values of the pointers, counters and output register.
    always_comb begin
        n_wr_ptr      = r_wr_ptr;
        n_rd_ptr      = r_rd_ptr;
        n_fetch_ptr   = r_fetch_ptr;
        n_fill        = r_fill;
        n_inflight    = r_inflight;
        n_remain      = r_remain;
        n_status_word = r_status_word;
        n_out_valid   = r_out_valid & ~o_out.ready;
        n_out_kind    = r_out_kind;
        n_out_acc     = r_out_acc;
        n_out_byte    = r_out_byte;
        n_out_last    = r_out_last;

        if (i_cfg.valid) begin
            n_status_word = i_cfg.data;
        end

        if (i_cmd.accept_push) begin
            if (push_ok) begin
                n_wr_ptr = (r_wr_ptr == PW'(TX_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
                n_fill   = r_fill + 1'b1;
            end
            n_out_kind = KIND_ACK;
            n_out_acc  = push_ok;
            n_out_byte = 8'h00;
            n_out_last = 1'b1;
        end

        if (i_cmd.accept_sent) begin
            n_rd_ptr    = rd_wrapped;
            n_fetch_ptr = rd_wrapped;
            n_fill      = fill_after;
            n_inflight  = CW'(chunk_m);
            n_remain    = CW'(chunk_m);
        end

        if (i_cmd.load_hdr_lo) begin
            n_out_kind = KIND_PKT;
            n_out_acc  = 1'b0;
            n_out_byte = r_status_word[7:0];
            n_out_last = 1'b0;
        end

        if (i_cmd.load_hdr_hi) begin
            n_out_kind = KIND_PKT;
            n_out_acc  = 1'b0;
            n_out_byte = r_status_word[15:8];
            n_out_last = (r_remain == '0);
        end

        if (i_cmd.load_data) begin
            n_out_kind = KIND_PKT;
            n_out_acc  = 1'b0;
            n_out_byte = r_rd_data;
            n_out_last = (r_remain == CW'(1));
            n_remain   = r_remain - 1'b1;
        end

        // The fetch pointer runs one byte ahead of the output register.
        if (rd_en) begin
            n_fetch_ptr = (r_fetch_ptr == PW'(TX_DEPTH - 1)) ? '0 : r_fetch_ptr + 1'b1;
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_fill        <= '0;
            r_inflight    <= '0;
            r_remain      <= '0;
            r_status_word <= STATUS_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_wr_ptr      <= n_wr_ptr;
            r_rd_ptr      <= n_rd_ptr;
            r_fill        <= n_fill;
            r_inflight    <= n_inflight;
            r_remain      <= n_remain;
            r_status_word <= n_status_word;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_fetch_ptr <= n_fetch_ptr;
        r_out_kind  <= n_out_kind;
        r_out_acc   <= n_out_acc;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_push && push_ok) begin
            r_ring[r_wr_ptr] <= i_put_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_ring[r_fetch_ptr];
        end
    end

    assign o_status.out_free   = ~r_out_valid | o_out.ready;
    assign o_status.chunk_zero = (r_remain == '0);
    assign o_status.data_last  = (r_remain == CW'(1));

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out_kind;
    assign o_out.accepted    = r_out_acc;
    assign o_out.packet_byte = r_out_byte;
    assign o_out.last        = r_out_last;

    assign i_cfg.ready = 1'b1;

    // The ring never holds more bytes than it has slots.
    `STB_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FW'(TX_DEPTH), "ring fill beyond depth")
    // The chunk in flight is always still held in the ring.
    `STB_ASSERT_NOW(a_inflight_held, 1'b1, MW'(r_inflight) <= MW'(r_fill),
        "chunk in flight larger than fill")
    // A waiting word is never overwritten.
    `STB_ASSERT_NOW(a_no_overwrite, r_out_valid && !o_out.ready, !out_load,
        "output word overwritten while stalled")
    // A stalled word keeps its value into the next cycle.
    `STB_ASSERT_NEXT(a_stall_hold, r_out_valid && !o_out.ready,
        r_out_valid && $stable(r_out_byte) && $stable(r_out_last),
        "stalled output word changed")

endmodule

>>> src/serial_tx_bulk_packetizer.sv
// Top level of the serial transmit ring buffer and bulk-in packetizer.
//
// Channels: i_in takes request words (req_type, put_byte); o_out gives
// result words (result_kind, accepted, packet_byte, last); i_cfg writes the
// 16-bit modem status word and is always ready.
// A push word is stored in the ring when there is room and gives one
// acknowledgement word in the output register in the cycle after it is
// taken, so pushes run at one per cycle while the receiver keeps up.
// A sent word retires the previous chunk and starts a packet: two status
// bytes, low first, then up to PACKET_BYTES-2 ring bytes. The first status
// byte is loaded in the cycle after the sent word is taken, then one byte per
// cycle while the receiver keeps up, set by the single output register and
// the registered ring read port. The next request is taken in ST_IDLE after
// the last packet byte is loaded, once the output register is free.
// Reset clears the read/write pointers and counts, sets the status word to
// 0x00B0; the ring contents are left as they are and need no clearing pass.
// When the receiver stalls, the output word holds and the sequence waits;
// no request is taken while the output register is full and not drained.
module serial_tx_bulk_packetizer #(
    parameter int TX_DEPTH     = stb_pkg::TX_DEPTH_DEF,
    parameter int PACKET_BYTES = stb_pkg::PACKET_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stb_in_if.sink    i_in,
    stb_out_if.source o_out,
    stb_cfg_if.sink   i_cfg
);
    import stb_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Controller.
    stb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // Datapath.
    stb_dp #(
        .TX_DEPTH     (TX_DEPTH),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_put_byte (i_in.put_byte),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out      (o_out),
        .i_cfg      (i_cfg)
    );

endmodule
